// ===== sv/tsp_pkg.sv =====
// Shared types and constants for the torus surface projection pipeline.
// No dependencies; every other file of the block but tsp_checker imports this package.
package tsp_pkg;

   localparam int CoordW = 32;
   localparam int RadW   = 31;
   localparam int RelW   = 33;
   localparam int OffW   = 35;
   localparam int MagW   = 64;
   localparam int NmW    = 31;
   localparam int LenW   = 32;
   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_MAJOR_R  = 3'd3,
      CSR_MINOR_R  = 3'd4
   } tsp_csr_type;

   typedef struct packed {
      logic valid;
      logic ok;
   } tsp_ctl_type;

endpackage

// ===== sv/torus_surface_projection.sv =====
// Top level: projects a point onto a torus surface, one word per clock while rsp_ is not stalled.
// Depends on tsp_pkg and tsp_unit.
//
//   channel  dir  payload
//   req_     in   tdata: point_x, point_y, point_z, height (32 bits each)
//   rsp_     out  tdata: surface_x/y/z (32), normal_x/y/z (FRAC_BITS+2); tuser: degenerate
//   csr_     in   index, data: center_x/y/z, major_radius, minor_radius
//
// Latency is set by the two normalizers, each with 32 square root cells and
// FRAC_BITS+1 divider cells. One word enters per cycle while rsp_ is not stalled.
// A stalled rsp_ channel freezes the whole pipeline; req_tready then drops.
// Reset clears the valid bits and loads the register defaults.
module torus_surface_projection #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // point_x, point_y, point_z, height
   input  logic [127:0]             req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // surface_x, surface_y, surface_z, normal_x, normal_y, normal_z, zero fill
   output logic [((96+3*(FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic                     rsp_tuser,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [tsp_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]              csr_data
);
   import tsp_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int NW     = F + 2;
   localparam int DataW  = 96 + 3 * NW;
   localparam int TdataW = ((DataW + 7) / 8) * 8;
   localparam int Sb1W   = 3 * RelW + CoordW;
   localparam int Sb2W   = 3 * RelW + CoordW + 1;

   logic en;

   // Configuration registers.
   logic signed [CoordW-1:0] center_ff [3];
   logic [RadW-1:0]          major_ff, minor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         major_ff     <= RadW'(131072);
         minor_ff     <= RadW'(65536);
      end else if (csr_valid) begin
         case (tsp_csr_type'(csr_index))
            CSR_CENTER_X: center_ff[0] <= csr_data;
            CSR_CENTER_Y: center_ff[1] <= csr_data;
            CSR_CENTER_Z: center_ff[2] <= csr_data;
            CSR_MAJOR_R:  major_ff     <= csr_data[RadW-1:0];
            CSR_MINOR_R:  minor_ff     <= csr_data[RadW-1:0];
            default: ;
         endcase
      end
   end

   // Relative point.
   logic                     v0_ff;
   logic signed [RelW-1:0]   rel0_ff [3];
   logic signed [RelW-1:0]   rel0_in [3];
   logic [CoordW-1:0]        hgt0_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rel0_in[i] = $signed({req_tdata[32*i+31], req_tdata[32*i +: 32]})
                    - $signed({center_ff[i][CoordW-1], center_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rel0_ff <= rel0_in;
         hgt0_ff <= req_tdata[127:96];
      end
   end

   // First normalizer on the xz projection.
   logic [2:0][OffW-1:0] vec1;
   tsp_ctl_type          ctl1;
   logic [2:0][NW-1:0]   dir1;
   logic [Sb1W-1:0]      sb1_o;

   assign vec1[0] = OffW'(rel0_ff[0]);
   assign vec1[1] = '0;
   assign vec1[2] = OffW'(rel0_ff[2]);

   tsp_unit #(.IN_W(OffW), .F(F), .SB_W(Sb1W)) u_unit_dir (
      .clock(clock), .reset(reset), .en(en), .valid_i(v0_ff), .vec_i(vec1),
      .sb_i({rel0_ff[0], rel0_ff[1], rel0_ff[2], hgt0_ff}),
      .ctl_o(ctl1), .unit_o(dir1), .sb_o(sb1_o)
   );

   // Center circle point.
   tsp_ctl_type              ctl_m1_ff;
   logic [2:0][F+RadW:0]     prod1_ff;
   logic [2:0]               neg1_ff;
   logic [Sb1W-1:0]          sb_m1_ff;
   logic [2:0][F:0]          dmag;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dmag[i] = dir1[i][NW-1] ? (F+1)'(NW'(0) - dir1[i]) : dir1[i][F:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_m1_ff <= '0;
      end else if (en) begin
         ctl_m1_ff <= ctl1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod1_ff[i] <= (F+RadW+1)'(dmag[i]) * (F+RadW+1)'(major_ff);
            neg1_ff[i]  <= dir1[i][NW-1];
         end
         sb_m1_ff <= sb1_o;
      end
   end

   tsp_ctl_type              ctl_m2_ff;
   logic [2:0][OffW-1:0]     off2_ff, off2_in;
   logic [2:0][RelW-1:0]     big2_ff, big2_in;
   logic [CoordW-1:0]        hgt2_ff;
   logic [2:0][RelW-1:0]     rel_m1;
   logic [2:0][RelW-2:0]     bmag;

   assign rel_m1[0] = sb_m1_ff[Sb1W-1 -: RelW];
   assign rel_m1[1] = sb_m1_ff[Sb1W-1-RelW -: RelW];
   assign rel_m1[2] = sb_m1_ff[Sb1W-1-2*RelW -: RelW];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bmag[i]    = (RelW-1)'(prod1_ff[i] >> F);
         big2_in[i] = neg1_ff[i] ? (RelW'(0) - {1'b0, bmag[i]}) : {1'b0, bmag[i]};
         off2_in[i] = OffW'($signed(rel_m1[i])) - OffW'($signed(big2_in[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_m2_ff <= '0;
      end else if (en) begin
         ctl_m2_ff <= ctl_m1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off2_ff <= off2_in;
         big2_ff <= big2_in;
         hgt2_ff <= sb_m1_ff[CoordW-1:0];
      end
   end

   // Second normalizer on the offset from the center circle.
   tsp_ctl_type          ctl2;
   logic [2:0][NW-1:0]   nrm2;
   logic [Sb2W-1:0]      sb2_o;

   tsp_unit #(.IN_W(OffW), .F(F), .SB_W(Sb2W)) u_unit_nrm (
      .clock(clock), .reset(reset), .en(en), .valid_i(ctl_m2_ff.valid), .vec_i(off2_ff),
      .sb_i({big2_ff, hgt2_ff, ctl_m2_ff.ok}),
      .ctl_o(ctl2), .unit_o(nrm2), .sb_o(sb2_o)
   );

   // Scaled normal.
   logic                       v3_ff, deg3_ff;
   logic [2:0][F+RelW:0]       prod3_ff;
   logic [2:0]                 neg3_ff;
   logic [2:0][RelW-1:0]       big3_ff;
   logic [2:0][NW-1:0]         nrm3_ff;
   logic signed [RelW:0]       scale;
   logic [RelW-1:0]            smag;
   logic [2:0][F:0]            nmag;

   always_comb begin
      scale = $signed({3'b000, minor_ff}) + $signed({{2{sb2_o[CoordW]}}, sb2_o[CoordW:1]});
      smag  = scale[RelW] ? RelW'((RelW+1)'(0) - scale) : scale[RelW-1:0];
      for (int i = 0; i < 3; i++) begin
         nmag[i] = nrm2[i][NW-1] ? (F+1)'(NW'(0) - nrm2[i]) : nrm2[i][F:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= ctl2.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod3_ff[i] <= (F+RelW+1)'(nmag[i]) * (F+RelW+1)'(smag);
            neg3_ff[i]  <= nrm2[i][NW-1] ^ scale[RelW];
         end
         big3_ff <= sb2_o[Sb2W-1 -: 3*RelW];
         nrm3_ff <= nrm2;
         deg3_ff <= ~sb2_o[0] | ~ctl2.ok;
      end
   end

   // Sum, saturation and output register.
   logic                      rsp_valid_ff, rsp_deg_ff;
   logic [2:0][CoordW-1:0]    surf_ff, surf_in;
   logic [2:0][NW-1:0]        rnrm_ff, rnrm_in;
   logic [2:0][RelW:0]        mmag;
   logic [2:0][OffW-1:0]      msgn, tot;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mmag[i] = (RelW+1)'(prod3_ff[i] >> F);
         msgn[i] = neg3_ff[i] ? (OffW'(0) - OffW'(mmag[i])) : OffW'(mmag[i]);
         tot[i]  = OffW'($signed(big3_ff[i])) + msgn[i];
         if (deg3_ff) begin
            surf_in[i] = '0;
         end else if ($signed(tot[i]) > $signed(OffW'(32'h7FFF_FFFF))) begin
            surf_in[i] = 32'h7FFF_FFFF;
         end else if ($signed(tot[i]) < $signed({{(OffW-CoordW){1'b1}}, 32'h8000_0000})) begin
            surf_in[i] = 32'h8000_0000;
         end else begin
            surf_in[i] = tot[i][CoordW-1:0];
         end
         rnrm_in[i] = deg3_ff ? '0 : nrm3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         surf_ff    <= surf_in;
         rnrm_ff    <= rnrm_in;
         rsp_deg_ff <= deg3_ff;
      end
   end

   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_deg_ff;
   assign rsp_tdata  = TdataW'({rnrm_ff[2], rnrm_ff[1], rnrm_ff[0],
                                surf_ff[2], surf_ff[1], surf_ff[0]});

endmodule

// ===== sv/tsp_norm_cell.sv =====
// One step of the left-normalizing shifter for three magnitudes.
// Depends on tsp_pkg.
module tsp_norm_cell #(
   parameter int SHIFT  = 32,
   parameter int PASS_W = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  tsp_pkg::tsp_ctl_type                 ctl_i,
   input  logic [2:0][tsp_pkg::MagW-1:0]        mag_i,
   input  logic [tsp_pkg::MagW-1:0]             max_i,
   input  logic [PASS_W-1:0]                    pass_i,
   output tsp_pkg::tsp_ctl_type                 ctl_o,
   output logic [2:0][tsp_pkg::MagW-1:0]        mag_o,
   output logic [tsp_pkg::MagW-1:0]             max_o,
   output logic [PASS_W-1:0]                    pass_o
);
   import tsp_pkg::*;

   tsp_ctl_type              ctl_ff;
   logic [2:0][MagW-1:0]     mag_ff, mag_in;
   logic [MagW-1:0]          max_ff, max_in;
   logic [PASS_W-1:0]        pass_ff;
   logic                     hit;

   always_comb begin
      hit = (max_i[MagW-1 -: SHIFT] == '0);
      max_in = hit ? (max_i << SHIFT) : max_i;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = hit ? (mag_i[i] << SHIFT) : mag_i[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         max_ff  <= max_in;
         pass_ff <= pass_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign mag_o  = mag_ff;
   assign max_o  = max_ff;
   assign pass_o = pass_ff;

endmodule

// ===== sv/tsp_sqrt_cell.sv =====
// One iteration of the bitwise integer square root, two radicand bits per cell.
// Depends on tsp_pkg.
module tsp_sqrt_cell #(
   parameter int STEP   = 0,
   parameter int PASS_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  tsp_pkg::tsp_ctl_type      ctl_i,
   input  logic [tsp_pkg::MagW-1:0]  x_i,
   input  logic [tsp_pkg::MagW-1:0]  res_i,
   input  logic [PASS_W-1:0]         pass_i,
   output tsp_pkg::tsp_ctl_type      ctl_o,
   output logic [tsp_pkg::MagW-1:0]  x_o,
   output logic [tsp_pkg::MagW-1:0]  res_o,
   output logic [PASS_W-1:0]         pass_o
);
   import tsp_pkg::*;

   localparam logic [MagW-1:0] Bit = MagW'(1) << (MagW - 2 - 2 * STEP);

   tsp_ctl_type       ctl_ff;
   logic [MagW-1:0]   x_ff, x_in, res_ff, res_in, trial;
   logic [PASS_W-1:0] pass_ff;

   always_comb begin
      trial = res_i + Bit;
      if (x_i >= trial) begin
         x_in   = x_i - trial;
         res_in = (res_i >> 1) + Bit;
      end else begin
         x_in   = x_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         res_ff  <= res_in;
         pass_ff <= pass_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign x_o    = x_ff;
   assign res_o  = res_ff;
   assign pass_o = pass_ff;

endmodule

// ===== sv/tsp_div_cell.sv =====
// One quotient bit of a restoring divider, three lanes sharing one divisor.
// Depends on tsp_pkg.
module tsp_div_cell #(
   parameter int BIT    = 0,
   parameter int QW     = 17,
   parameter int PASS_W = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  tsp_pkg::tsp_ctl_type            ctl_i,
   input  logic [2:0][tsp_pkg::MagW-1:0]   rem_i,
   input  logic [2:0][QW-1:0]              q_i,
   input  logic [tsp_pkg::LenW-1:0]        len_i,
   input  logic [PASS_W-1:0]               pass_i,
   output tsp_pkg::tsp_ctl_type            ctl_o,
   output logic [2:0][tsp_pkg::MagW-1:0]   rem_o,
   output logic [2:0][QW-1:0]              q_o,
   output logic [tsp_pkg::LenW-1:0]        len_o,
   output logic [PASS_W-1:0]               pass_o
);
   import tsp_pkg::*;

   tsp_ctl_type            ctl_ff;
   logic [2:0][MagW-1:0]   rem_ff, rem_in;
   logic [2:0][QW-1:0]     q_ff, q_in;
   logic [LenW-1:0]        len_ff;
   logic [PASS_W-1:0]      pass_ff;
   logic [MagW-1:0]        divisor;
   logic [2:0]             ge;

   always_comb begin
      divisor = MagW'(len_i) << BIT;
      for (int i = 0; i < 3; i++) begin
         ge[i]     = (rem_i[i] >= divisor);
         rem_in[i] = ge[i] ? (rem_i[i] - divisor) : rem_i[i];
         q_in[i]   = {q_i[i][QW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         len_ff  <= len_i;
         pass_ff <= pass_i;
      end
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign q_o    = q_ff;
   assign len_o  = len_ff;
   assign pass_o = pass_ff;

endmodule

// ===== sv/tsp_unit.sv =====
// Pipelined 3-vector normalizer: shifter cells, squares, square root cells and
// divider cells. Depends on tsp_pkg, tsp_norm_cell, tsp_sqrt_cell, tsp_div_cell.
module tsp_unit #(
   parameter int IN_W = 35,
   parameter int F    = 16,
   parameter int SB_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        valid_i,
   input  logic [2:0][IN_W-1:0]        vec_i,
   input  logic [SB_W-1:0]             sb_i,
   output tsp_pkg::tsp_ctl_type        ctl_o,
   output logic [2:0][F+1:0]           unit_o,
   output logic [SB_W-1:0]             sb_o
);
   import tsp_pkg::*;

   localparam int QW      = F + 1;
   localparam int NPASS_W = 3 + SB_W;
   localparam int SPASS_W = 3 * NmW + 3 + SB_W;
   localparam int SqrtN   = 32;
   localparam int DivN    = F + 1;

   // Magnitudes, signs and maximum.
   tsp_ctl_type           ctl0_ff, ctl0_in;
   logic [2:0][MagW-1:0]  mag0_ff, mag0_in;
   logic [MagW-1:0]       max0_ff, max0_in, max01;
   logic [2:0]            neg0_ff, neg0_in;
   logic [SB_W-1:0]       sb0_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg0_in[i] = vec_i[i][IN_W-1];
         mag0_in[i] = neg0_in[i] ? (MagW'(0) - {{(MagW-IN_W){vec_i[i][IN_W-1]}}, vec_i[i]})
                                 : {{(MagW-IN_W){1'b0}}, vec_i[i]};
      end
      max01   = (mag0_in[0] > mag0_in[1]) ? mag0_in[0] : mag0_in[1];
      max0_in = (max01 > mag0_in[2]) ? max01 : mag0_in[2];
      ctl0_in.valid = valid_i;
      ctl0_in.ok    = (max0_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (en) begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag0_ff <= mag0_in;
         max0_ff <= max0_in;
         neg0_ff <= neg0_in;
         sb0_ff  <= sb_i;
      end
   end

   // Shifter cells.
   tsp_ctl_type           n_ctl  [0:6];
   logic [2:0][MagW-1:0]  n_mag  [0:6];
   logic [MagW-1:0]       n_max  [0:6];
   logic [NPASS_W-1:0]    n_pass [0:6];

   assign n_ctl[0]  = ctl0_ff;
   assign n_mag[0]  = mag0_ff;
   assign n_max[0]  = max0_ff;
   assign n_pass[0] = {neg0_ff, sb0_ff};

   for (genvar g = 0; g < 6; g++) begin : g_norm
      tsp_norm_cell #(.SHIFT(32 >> g), .PASS_W(NPASS_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .ctl_i(n_ctl[g]), .mag_i(n_mag[g]), .max_i(n_max[g]), .pass_i(n_pass[g]),
         .ctl_o(n_ctl[g+1]), .mag_o(n_mag[g+1]), .max_o(n_max[g+1]), .pass_o(n_pass[g+1])
      );
   end

   // Squares, then their sum.
   tsp_ctl_type            ctl1_ff, ctl2_ff;
   logic [2:0][NmW-1:0]    mn1_ff, mn2_ff, mn_in;
   logic [2:0][2*NmW-1:0]  sq1_ff;
   logic [NPASS_W-1:0]     pass1_ff, pass2_ff;
   logic [MagW-1:0]        sum2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mn_in[i] = n_mag[6][i][MagW-1 -: NmW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (en) begin
         ctl1_ff <= n_ctl[6];
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq1_ff[i] <= (2*NmW)'(mn_in[i]) * (2*NmW)'(mn_in[i]);
         end
         mn1_ff   <= mn_in;
         pass1_ff <= n_pass[6];
         sum2_ff  <= MagW'(sq1_ff[0]) + MagW'(sq1_ff[1]) + MagW'(sq1_ff[2]);
         mn2_ff   <= mn1_ff;
         pass2_ff <= pass1_ff;
      end
   end

   // Square root cells.
   tsp_ctl_type         s_ctl  [0:SqrtN];
   logic [MagW-1:0]     s_x    [0:SqrtN];
   logic [MagW-1:0]     s_res  [0:SqrtN];
   logic [SPASS_W-1:0]  s_pass [0:SqrtN];

   assign s_ctl[0]  = ctl2_ff;
   assign s_x[0]    = sum2_ff;
   assign s_res[0]  = '0;
   assign s_pass[0] = {mn2_ff, pass2_ff};

   for (genvar g = 0; g < SqrtN; g++) begin : g_sqrt
      tsp_sqrt_cell #(.STEP(g), .PASS_W(SPASS_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .ctl_i(s_ctl[g]), .x_i(s_x[g]), .res_i(s_res[g]), .pass_i(s_pass[g]),
         .ctl_o(s_ctl[g+1]), .x_o(s_x[g+1]), .res_o(s_res[g+1]), .pass_o(s_pass[g+1])
      );
   end

   // Divider cells.
   tsp_ctl_type           d_ctl  [0:DivN];
   logic [2:0][MagW-1:0]  d_rem  [0:DivN];
   logic [2:0][QW-1:0]    d_q    [0:DivN];
   logic [LenW-1:0]       d_len  [0:DivN];
   logic [NPASS_W-1:0]    d_pass [0:DivN];
   logic [2:0][NmW-1:0]   s_mn;

   assign s_mn = s_pass[SqrtN][SPASS_W-1 -: 3*NmW];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_rem[0][i] = MagW'(s_mn[i]) << F;
      end
   end

   assign d_ctl[0]  = s_ctl[SqrtN];
   assign d_q[0]    = '0;
   assign d_len[0]  = s_res[SqrtN][LenW-1:0];
   assign d_pass[0] = s_pass[SqrtN][NPASS_W-1:0];

   for (genvar g = 0; g < DivN; g++) begin : g_div
      tsp_div_cell #(.BIT(F - g), .QW(QW), .PASS_W(NPASS_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .ctl_i(d_ctl[g]), .rem_i(d_rem[g]), .q_i(d_q[g]), .len_i(d_len[g]),
         .pass_i(d_pass[g]),
         .ctl_o(d_ctl[g+1]), .rem_o(d_rem[g+1]), .q_o(d_q[g+1]), .len_o(d_len[g+1]),
         .pass_o(d_pass[g+1])
      );
   end

   // Signed result.
   tsp_ctl_type        ctl3_ff;
   logic [2:0][F+1:0]  unit3_ff, unit3_in;
   logic [SB_W-1:0]    sb3_ff;
   logic [2:0]         dneg;

   assign dneg = d_pass[DivN][NPASS_W-1 -: 3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit3_in[i] = dneg[i] ? ((F+2)'(0) - (F+2)'(d_q[DivN][i]))
                               : (F+2)'(d_q[DivN][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else if (en) begin
         ctl3_ff <= d_ctl[DivN];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit3_ff <= unit3_in;
         sb3_ff   <= d_pass[DivN][SB_W-1:0];
      end
   end

   assign ctl_o  = ctl3_ff;
   assign unit_o = unit3_ff;
   assign sb_o   = sb3_ff;

endmodule

// ===== sv/tsp_checker.sv =====
// Port-level checks for the torus surface projection and their binding.
// Depends on torus_surface_projection.
module tsp_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [((96+3*(FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   input logic                     rsp_tuser
);
   localparam int NW = FRAC_BITS + 2;
   localparam logic signed [NW-1:0] NPos = NW'(1) << FRAC_BITS;
   localparam logic signed [NW-1:0] NNeg = -NPos;

   logic signed [NW-1:0] nx;

   assign nx = rsp_tdata[96 +: NW];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result word changed while stalled.");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled with an empty output register.");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("Degenerate result carries nonzero data.");

   a_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> nx <= NPos && nx >= NNeg)
      else $error("Normal component exceeds one.");

endmodule

bind torus_surface_projection tsp_checker #(.FRAC_BITS(FRAC_BITS)) u_tsp_checker (
   .clock(clock), .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
